// ===== src/ahfb_pkg.sv =====
// Shared types, constants and helpers for the ASCII hex frame builder.
`timescale 1ns / 1ps

package ahfb_pkg;

   localparam int MaxDataLen = 1024;
   localparam int IdLen      = 16;
   localparam int LenW       = 11;
   localparam int HdrLen     = 26;   // header bytes after STX
   localparam int QDepth     = 4;
   localparam int QPtrW      = $clog2(QDepth);
   localparam int QCntW      = $clog2(QDepth + 1);
   localparam int ReqDataW   = 72;

   localparam logic [2:0] OpStart = 3'd0;
   localparam logic [2:0] OpData  = 3'd1;
   localparam logic [2:0] OpLoad  = 3'd2;
   localparam logic [2:0] OpMove  = 3'd3;
   localparam logic [2:0] OpClear = 3'd4;

   localparam logic [1:0] ModeStored = 2'd1;
   localparam logic [1:0] ModeExc    = 2'd2;

   localparam logic CsrPrefixHigh = 1'b0;
   localparam logic CsrPrefixLast = 1'b1;

   localparam logic [7:0] ChStx    = 8'h02;
   localparam logic [7:0] ChEtx    = 8'h03;
   localparam logic [7:0] ChLbrace = 8'h7B;
   localparam logic [7:0] ChRbrace = 8'h7D;
   localparam logic [7:0] ChDash   = 8'h2D;
   localparam logic [7:0] ChZero   = 8'h30;
   localparam logic [7:0] ChOne    = 8'h31;

   localparam logic [15:0] HeaderFixed = 16'd26;
   localparam logic [15:0] CtrWrap     = 16'hFFFF;

   typedef enum logic [2:0] {
      KIND_START,
      KIND_DATA,
      KIND_LOAD,
      KIND_MOVE,
      KIND_CLEAR
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [39:0]       api;
      logic [LenW-1:0]   len;
      logic [1:0]        mode;
      logic [7:0]        value;
      logic [3:0]        idx;
   } entry_type;

   typedef struct packed {
      logic             full;
      logic             empty;
      logic [QCntW-1:0] count;
   } qstat_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) r = 8'h30 + {4'h0, nib};
      else r = 8'h37 + {4'h0, nib};
      return r;
   endfunction

endpackage

// ===== src/ahfb_front.sv =====
// Front end: accepts request words, decodes the opcode and clamps the length.
`timescale 1ns / 1ps

module ahfb_front import ahfb_pkg::*; (
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2:0]          req_tuser,
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                q_full,
   output logic                push,
   output entry_type           entry
);

   logic [LenW-1:0] raw_len;
   logic            known;

   assign req_tready = !q_full;
   assign raw_len    = req_tdata[50:40];

   always_comb begin
      known       = 1'b1;
      entry.kind  = KIND_START;
      entry.api   = req_tdata[39:0];
      entry.len   = (raw_len > LenW'(MaxDataLen)) ? LenW'(MaxDataLen) : raw_len;
      entry.mode  = req_tdata[52:51];
      entry.value = req_tdata[60:53];
      entry.idx   = req_tdata[64:61];
      unique case (req_tuser)
         OpStart: entry.kind = KIND_START;
         OpData:  entry.kind = KIND_DATA;
         OpLoad:  entry.kind = KIND_LOAD;
         OpMove:  entry.kind = KIND_MOVE;
         OpClear: entry.kind = KIND_CLEAR;
         default: known = 1'b0;   // unused opcodes are dropped here
      endcase
   end

   assign push = req_tvalid && req_tready && known;

endmodule

// ===== src/ahfb_queue.sv =====
// Small FIFO of decoded words between front end and frame sequencer.
`timescale 1ns / 1ps

module ahfb_queue import ahfb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type din,
   input  logic      pop,
   output entry_type dout,
   output qstat_type stat
);

   entry_type        mem [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign stat.full  = (count_ff == QCntW'(QDepth));
   assign stat.empty = (count_ff == '0);
   assign stat.count = count_ff;
   assign dout       = mem[rd_ptr_ff];

   assign do_push = push && !stat.full;
   assign do_pop  = pop && !stat.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= din;
   end

endmodule

// ===== src/ahfb_back.sv =====
// Frame sequencer: runs queued words, owns the ID stores and the output register.
`timescale 1ns / 1ps

module ahfb_back import ahfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  entry_type   head,
   output logic        pop,
   input  logic [63:0] prefix_high,
   input  logic [7:0]  prefix_last,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   typedef enum logic [1:0] {ST_IDLE, ST_HEAD, ST_TRAIL} state_type;

   state_type                  state_ff, state_in;
   logic [HdrLen-1:0][7:0]     hdr_ff, hdr_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic [LenW-1:0]            left_ff, left_in;
   logic [7:0]                 sum_ff, sum_in;
   logic [7:0]                 chk_ff, chk_in;
   logic [15:0]                ctr_ff, ctr_in;
   logic [IdLen-1:0][7:0]      sto_ff, sto_in;
   logic [IdLen-1:0][7:0]      exc_ff, exc_in;
   logic                       out_valid_ff, out_valid_in;
   logic [7:0]                 out_byte_ff, out_byte_in;
   logic                       out_last_ff, out_last_in;

   logic                       adv, emit, emit_last;
   logic [7:0]                 emit_byte, sum_base;
   logic [15:0]                body, ctr_inc;
   logic [IdLen-1:0][7:0]      gen_id, sel_id;
   logic                       use_exc, use_sto;

   assign adv        = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

   // ID candidates for a start word
   always_comb begin
      for (int k = 0; k < 8; k++) gen_id[k] = prefix_high[63 - 8*k -: 8];
      gen_id[8]  = prefix_last;
      gen_id[9]  = hex_char(ctr_ff[15:12]);
      gen_id[10] = hex_char(ctr_ff[11:8]);
      gen_id[11] = hex_char(ctr_ff[7:4]);
      gen_id[12] = hex_char(ctr_ff[3:0]);
      gen_id[13] = ChDash;
      gen_id[14] = ChZero;
      gen_id[15] = ChOne;
      use_exc = (head.mode == ModeExc) && (exc_ff[0] != 8'h00);
      use_sto = (head.mode == ModeStored) && (sto_ff[0] != 8'h00);
      if (use_exc) sel_id = exc_ff;
      else if (use_sto) sel_id = sto_ff;
      else sel_id = gen_id;
      body    = HeaderFixed + 16'(head.len);
      ctr_inc = ctr_ff + 16'd1;
   end

   always_comb begin
      state_in  = state_ff;
      hdr_in    = hdr_ff;
      cnt_in    = cnt_ff;
      left_in   = left_ff;
      chk_in    = chk_ff;
      ctr_in    = ctr_ff;
      sto_in    = sto_ff;
      exc_in    = exc_ff;
      pop       = 1'b0;
      emit      = 1'b0;
      emit_byte = 8'h00;
      emit_last = 1'b0;
      sum_base  = sum_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               unique case (head.kind)
                  KIND_START: begin
                     if (adv) begin
                        pop       = 1'b1;
                        emit      = 1'b1;
                        emit_byte = ChStx;
                        sum_base  = 8'h00;
                        hdr_in[0] = hex_char(body[15:12]);
                        hdr_in[1] = hex_char(body[11:8]);
                        hdr_in[2] = hex_char(body[7:4]);
                        hdr_in[3] = hex_char(body[3:0]);
                        for (int k = 0; k < 5; k++) hdr_in[4 + k] = head.api[39 - 8*k -: 8];
                        for (int k = 0; k < IdLen; k++) hdr_in[9 + k] = sel_id[k];
                        hdr_in[HdrLen-1] = ChLbrace;
                        if (use_exc) exc_in = '0;
                        else if (use_sto) sto_in = '0;
                        else ctr_in = (ctr_inc == CtrWrap) ? 16'h0000 : ctr_inc;
                        left_in  = head.len;
                        cnt_in   = '0;
                        state_in = ST_HEAD;
                     end
                  end
                  KIND_DATA: begin
                     if (left_ff == '0) begin
                        pop = 1'b1;   // no open frame: dropped
                     end else if (adv) begin
                        pop       = 1'b1;
                        emit      = 1'b1;
                        emit_byte = head.value;
                        left_in   = left_ff - 1'b1;
                        if (left_ff == LenW'(1)) begin
                           cnt_in   = '0;
                           state_in = ST_TRAIL;
                        end
                     end
                  end
                  KIND_LOAD: begin
                     pop              = 1'b1;
                     sto_in[head.idx] = head.value;
                  end
                  KIND_MOVE: begin
                     pop    = 1'b1;
                     exc_in = sto_ff;
                     sto_in = '0;
                  end
                  KIND_CLEAR: begin
                     pop    = 1'b1;
                     sto_in = '0;
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         ST_HEAD: begin
            if (adv) begin
               emit      = 1'b1;
               emit_byte = hdr_ff[0];
               for (int k = 0; k < HdrLen - 1; k++) hdr_in[k] = hdr_ff[k + 1];
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == 5'(HdrLen - 1)) begin
                  cnt_in   = '0;
                  state_in = (left_ff == '0) ? ST_TRAIL : ST_IDLE;
               end
            end
         end
         ST_TRAIL: begin
            if (adv) begin
               emit   = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               unique case (cnt_ff[1:0])
                  2'd0: begin
                     emit_byte = ChRbrace;
                     chk_in    = sum_ff + ChRbrace;
                  end
                  2'd1: emit_byte = hex_char(chk_ff[7:4]);
                  2'd2: emit_byte = hex_char(chk_ff[3:0]);
                  default: begin
                     emit_byte = ChEtx;
                     emit_last = 1'b1;
                     left_in   = '0;
                     state_in  = ST_IDLE;
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase

      sum_in = emit ? sum_base + emit_byte : sum_ff;

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (adv) begin
         out_valid_in = emit;
         out_byte_in  = emit_byte;
         out_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         left_ff      <= '0;
         sum_ff       <= '0;
         ctr_ff       <= '0;
         sto_ff       <= '0;
         exc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         left_ff      <= left_in;
         sum_ff       <= sum_in;
         ctr_ff       <= ctr_in;
         sto_ff       <= sto_in;
         exc_ff       <= exc_in;
         out_valid_ff <= out_valid_in;
      end
      hdr_ff      <= hdr_in;
      chk_ff      <= chk_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

endmodule

// ===== src/ascii_hex_frame_builder.sv =====
// Top level of the ASCII hex frame builder: config registers, front, queue, sequencer.
`timescale 1ns / 1ps
// A word accepted on req is written to the queue; its first byte then goes through the
// sequencer's output register to rsp, given an empty queue and an idle sequencer.
// Throughput: one output word per cycle unless rsp stalls; a start word emits STX and the
// header, plus the trailer at zero length; a data word its byte, the last also the trailer.
// Synchronous reset clears the queue, the ID stores, the counter and the prefix registers.

module ascii_hex_frame_builder import ahfb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,  // api_code[39:0], data_len[50:40], id_mode[52:51],
                                           // byte_value[60:53], id_index[64:61], zero pad
   input  logic [2:0]          req_tuser,  // opcode[2:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,  // out_byte[7:0]
   output logic                rsp_tlast,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [63:0]         csr_data
);

   logic [63:0] prefix_high_ff;
   logic [7:0]  prefix_last_ff;
   logic        push, pop;
   entry_type   front_entry, head_entry;
   qstat_type   qstat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_high_ff <= '0;
         prefix_last_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CsrPrefixHigh) prefix_high_ff <= csr_data;
         else prefix_last_ff <= csr_data[7:0];
      end
   end

   ahfb_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (qstat.full),
      .push       (push),
      .entry      (front_entry)
   );

   ahfb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (front_entry),
      .pop   (pop),
      .dout  (head_entry),
      .stat  (qstat)
   );

   ahfb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (qstat.empty),
      .head        (head_entry),
      .pop         (pop),
      .prefix_high (prefix_high_ff),
      .prefix_last (prefix_last_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("queue read while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      qstat.count <= QCntW'(QDepth))
      else $error("queue count out of range");

   a_last_is_etx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == ChEtx)
      else $error("frame end word is not ETX");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the ASCII hex frame builder: directed and random words, scored per byte.
`timescale 1ns / 1ps

module tb;
   import ahfb_pkg::*;

   localparam logic [1:0] ModeGen  = 2'd0;
   localparam logic [1:0] ModeNone = 2'd3;   // undefined mode, falls back to a generated id
   localparam logic [2:0] OpSpare5 = 3'd5;
   localparam logic [2:0] OpSpare7 = 3'd7;
   localparam int MaxGap   = 19;
   localparam int Drain    = 40;

   typedef struct packed {
      logic [2:0]  op;
      logic [39:0] api;
      logic [10:0] len;
      logic [1:0]  mode;
      logic [7:0]  value;
      logic [3:0]  idx;
   } word_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eof;
   } frame_byte_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic [2:0]          req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [7:0]          rsp_tdata;
   logic                rsp_tlast;
   logic                csr_valid;
   logic                csr_ready;
   logic                csr_index;
   logic [63:0]         csr_data;

   // shadow of the block's state
   logic [63:0] pfx_high;
   logic [7:0]  pfx_last;
   logic [7:0]  id_held  [IdLen];
   logic [7:0]  id_saved [IdLen];
   logic [15:0] req_count;
   logic [7:0]  csum;
   logic [10:0] data_remaining;
   logic        frame_active;

   frame_byte_type frame_bytes_due[$];
   int             errors;
   int             words_sent;
   bit             tx_fast;
   bit             rx_fast;

   ascii_hex_frame_builder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(8_000_000);
      $display("FAIL");
      $finish;
   end

   function automatic int pick_gap(input bit fast);
      return fast ? 0 : $urandom_range(0, MaxGap);
   endfunction

   function automatic logic [7:0] hex_ascii(input logic [3:0] n);
      return (n < 4'd10) ? ChZero + 8'(n) : 8'h41 + 8'(n) - 8'd10;
   endfunction

   function automatic void push_frame_byte(input logic [7:0] ch, input logic eof);
      frame_bytes_due.push_back('{ch: ch, eof: eof});
      csum += ch;
   endfunction

   function automatic void close_frame();
      logic [7:0] s;
      push_frame_byte(ChRbrace, 1'b0);
      s = csum;
      push_frame_byte(hex_ascii(s[7:4]), 1'b0);
      push_frame_byte(hex_ascii(s[3:0]), 1'b0);
      push_frame_byte(ChEtx, 1'b1);
      frame_active   = 1'b0;
      data_remaining = '0;
   endfunction

   // Expected frame bytes caused by one accepted word; updates the shadow state.
   function automatic void build_frame_bytes(input word_type w);
      logic [10:0] n;
      logic [15:0] body;
      int          i;
      case (w.op)
         OpStart: begin
            n    = (w.len > MaxDataLen) ? 11'(MaxDataLen) : w.len;
            body = HeaderFixed + 16'(n);
            csum = '0;
            push_frame_byte(ChStx, 1'b0);
            for (i = 3; i >= 0; i--) push_frame_byte(hex_ascii(body[4*i +: 4]), 1'b0);
            for (i = 4; i >= 0; i--) push_frame_byte(w.api[8*i +: 8], 1'b0);
            if (w.mode == ModeExc && id_saved[0] != 8'h00) begin
               for (i = 0; i < IdLen; i++) push_frame_byte(id_saved[i], 1'b0);
               foreach (id_saved[j]) id_saved[j] = 8'h00;
            end else if (w.mode == ModeStored && id_held[0] != 8'h00) begin
               for (i = 0; i < IdLen; i++) push_frame_byte(id_held[i], 1'b0);
               foreach (id_held[j]) id_held[j] = 8'h00;
            end else begin
               for (i = 7; i >= 0; i--) push_frame_byte(pfx_high[8*i +: 8], 1'b0);
               push_frame_byte(pfx_last, 1'b0);
               for (i = 3; i >= 0; i--) push_frame_byte(hex_ascii(req_count[4*i +: 4]), 1'b0);
               push_frame_byte(ChDash, 1'b0);
               push_frame_byte(ChZero, 1'b0);
               push_frame_byte(ChOne, 1'b0);
               req_count++;
               if (req_count == CtrWrap) req_count = '0;
            end
            push_frame_byte(ChLbrace, 1'b0);
            frame_active   = 1'b1;
            data_remaining = n;
            if (n == '0) close_frame();
         end
         OpData: begin
            if (frame_active && data_remaining != '0) begin
               push_frame_byte(w.value, 1'b0);
               data_remaining--;
               if (data_remaining == '0) close_frame();
            end
         end
         OpLoad: id_held[w.idx] = w.value;
         OpMove: begin
            id_saved = id_held;
            foreach (id_held[j]) id_held[j] = 8'h00;
         end
         OpClear: foreach (id_held[j]) id_held[j] = 8'h00;
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
   endtask

   // Word with every field random; callers overwrite what matters.
   function automatic word_type noise_word();
      word_type w;
      w.op    = 3'($urandom);
      w.api   = {8'($urandom), 32'($urandom)};
      w.len   = 11'($urandom);
      w.mode  = 2'($urandom);
      w.value = 8'($urandom);
      w.idx   = 4'($urandom);
      return w;
   endfunction

   task automatic send_word(input word_type w);
      int gap;
      gap = pick_gap(tx_fast);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= w.op;
      req_tdata  <= {7'd0, w.idx, w.value, w.mode, w.len, w.api};
      do @(posedge clock); while (!req_tready);
      build_frame_bytes(w);
      if (w.op <= OpClear) words_sent++;
   endtask

   task automatic do_start(input logic [39:0] api, input logic [10:0] len,
                           input logic [1:0] mode);
      word_type w;
      w      = noise_word();
      w.op   = OpStart;
      w.api  = api;
      w.len  = len;
      w.mode = mode;
      send_word(w);
   endtask

   task automatic do_data(input logic [7:0] value);
      word_type w;
      w       = noise_word();
      w.op    = OpData;
      w.value = value;
      send_word(w);
   endtask

   task automatic do_load(input logic [3:0] idx, input logic [7:0] value);
      word_type w;
      w       = noise_word();
      w.op    = OpLoad;
      w.idx   = idx;
      w.value = value;
      send_word(w);
   endtask

   task automatic do_cmd(input logic [2:0] op);
      word_type w;
      w    = noise_word();
      w.op = op;
      send_word(w);
   endtask

   // Hold the sender until every frame byte is out, then let queued id words settle.
   task automatic quiesce();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (Drain) @(posedge clock);
   endtask

   task automatic write_csr(input logic sel, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (sel == CsrPrefixHigh) pfx_high = value;
      else pfx_last = value[7:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_prefix(input logic [63:0] high, input logic [63:0] last_char);
      quiesce();
      write_csr(CsrPrefixHigh, high);
      write_csr(CsrPrefixLast, last_char);
   endtask

   function automatic logic [7:0] pick_data();
      int r;
      r = $urandom_range(0, 9);
      return (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
   endfunction

   function automatic logic [39:0] pick_api();
      return {8'($urandom), 32'($urandom)};
   endfunction

   // Reset prefix, empty frame, stray data, spare opcodes, then all-ones prefix.
   task automatic test_basic_frames();
      do_start(40'h00_0000_0000, 11'd0, ModeGen);
      do_data(8'hA5);                           // no frame open, dropped
      do_cmd(OpSpare5);
      do_cmd(OpSpare7);
      set_prefix(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      do_start(40'hFF_FFFF_FFFF, 11'd1, ModeNone);
      do_data(8'h00);
      set_prefix(64'h5245_512D_4142_4344, 64'h0000_0000_0000_005F);
   endtask

   task automatic test_id_stores();
      do_load(4'd0, 8'h52);
      do_load(4'd15, 8'hFF);
      do_load(4'd7, 8'h80);                     // other bytes stay zero and go out as zero
      do_start(pick_api(), 11'd1, ModeStored);
      do_data(8'hFF);
      do_start(pick_api(), 11'd0, ModeStored);  // store was emptied
      do_load(4'd0, 8'h01);
      do_cmd(OpMove);
      do_start(pick_api(), 11'd0, ModeExc);
      do_start(pick_api(), 11'd0, ModeExc);     // exception store now empty
      do_load(4'd5, 8'h41);
      do_start(pick_api(), 11'd0, ModeStored);  // first byte zero, so generated
      do_load(4'd0, 8'h7E);
      do_cmd(OpClear);
      do_start(pick_api(), 11'd0, ModeStored);
   endtask

   // Oversized length, id words inside an open frame, restart without trailer.
   task automatic test_abandon();
      do_start(pick_api(), 11'h7FF, ModeGen);
      do_data(pick_data());
      do_load(4'd3, 8'($urandom));
      do_start(pick_api(), 11'd2, ModeGen);
      do_cmd(OpMove);
      do_data(pick_data());
      do_data(pick_data());
   endtask

   // Length above the maximum shows up saturated in the header; burst, then restart.
   task automatic test_max_length();
      tx_fast = 1'b1;
      rx_fast = 1'b1;
      do_start(pick_api(), 11'd1500, 2'($urandom));
      repeat (8) do_data(pick_data());
      do_start(pick_api(), 11'd1, ModeGen);
      do_data(pick_data());
      quiesce();
      tx_fast = 1'b0;
      rx_fast = 1'b0;
   endtask

   task automatic test_random();
      int base, cfg_at, kind, r, n, k, i;
      logic [10:0] len;
      base   = words_sent;
      cfg_at = 50;
      while (words_sent - base < 160) begin
         if (words_sent - base >= cfg_at) begin
            r = $urandom_range(0, 3);
            set_prefix(r == 0 ? 64'd0 : r == 1 ? '1 : {32'($urandom), 32'($urandom)},
                       {32'($urandom), 32'($urandom)});
            cfg_at += 50;
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
         end
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            r = $urandom_range(0, 19);
            if (r < 13) len = 11'($urandom_range(0, 6));
            else if (r < 19) len = 11'($urandom_range(7, 24));
            else len = 11'($urandom_range(MaxDataLen + 1, 2047));
            do_start(pick_api(), len, 2'($urandom));
            n = (len > MaxDataLen) ? $urandom_range(0, 5) : int'(len);
            if ($urandom_range(0, 5) == 0) n = $urandom_range(0, n);   // cut short
            for (i = 0; i < n; i++) begin
               if ($urandom_range(0, 7) == 0) begin
                  k = $urandom_range(0, 2);
                  if (k == 0) do_load(4'($urandom), 8'($urandom));
                  else do_cmd(k == 1 ? OpMove : OpClear);
               end
               do_data(pick_data());
            end
         end else if (kind < 8) begin
            do_load(4'd0, 8'($urandom_range(1, 255)));
            repeat ($urandom_range(0, 4)) do_load(4'($urandom), 8'($urandom));
            if ($urandom_range(0, 1) == 1) do_cmd(OpMove);
         end else if (kind == 8) begin
            send_word(noise_word());
         end else begin
            do_cmd($urandom_range(0, 1) == 1 ? OpMove : OpClear);
         end
         if ($urandom_range(0, 19) == 0) quiesce();
      end
   endtask

   // Sink side: random stall before each byte.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         stall = pick_gap(rx_fast);
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      frame_byte_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (frame_bytes_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h last %b", rsp_tdata, rsp_tlast));
         end else begin
            due = frame_bytes_due.pop_front();
            if (rsp_tdata !== due.ch)
               report_mismatch($sformatf("byte %h, expected %h", rsp_tdata, due.ch));
            if (rsp_tlast !== due.eof)
               report_mismatch($sformatf("last %b, expected %b", rsp_tlast, due.eof));
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = CsrPrefixHigh;
      csr_data   = '0;
      tx_fast    = 1'b0;
      rx_fast    = 1'b0;
      errors     = 0;
      words_sent = 0;
      pfx_high   = '0;
      pfx_last   = '0;
      foreach (id_held[j]) id_held[j] = 8'h00;
      foreach (id_saved[j]) id_saved[j] = 8'h00;
      req_count      = '0;
      csum           = '0;
      data_remaining = '0;
      frame_active   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_frames();
      test_id_stores();
      test_abandon();
      test_max_length();
      test_random();

      quiesce();
      if (errors == 0 && frame_bytes_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/ahfb_pkg.sv
src/ahfb_front.sv
src/ahfb_queue.sv
src/ahfb_back.sv
src/ascii_hex_frame_builder.sv
bench/tb.sv
